FILE: rtl/wlpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlpf_pkg: shared definitions of the windowed local peak finder
// Default sizes, configuration reset value, queue depth and back-end states.
// ----------------------------------------------------------------------------
package wlpf_pkg;

    // default sizes handed to the top level
    localparam int HISTORY_DEPTH_DEF   = 64;
    localparam int MAX_HALF_WINDOW_DEF = 15;
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int INDEX_WIDTH_DEF     = 16;

    // configuration register
    localparam int CFG_WIDTH = 4;
    localparam logic [CFG_WIDTH-1:0] HALF_WINDOW_RST = CFG_WIDTH'(3);

    // result position width
    localparam int POS_WIDTH = 16;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_VAL,
        B_SCAN,
        B_EMIT,
        B_NEXT,
        B_CLOSE
    } t_back_state;

endpackage
`default_nettype wire

FILE: rtl/wlpf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlpf_in_if: sample channel
// Valid/ready channel that carries one signed sample and the series end flag.
// ----------------------------------------------------------------------------
interface wlpf_in_if #(
    parameter int SAMPLE_WIDTH = wlpf_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           series_end;

    modport source (output valid, output sample, output series_end, input ready);
    modport sink   (input valid, input sample, input series_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/wlpf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlpf_out_if: peak result channel
// Valid/ready channel that carries one peak position or the closing result.
// ----------------------------------------------------------------------------
interface wlpf_out_if;
    import wlpf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [POS_WIDTH-1:0] peak_position;
    logic                 is_peak;
    logic                 run_last;

    modport source (output valid, output peak_position, output is_peak, output run_last,
                    input ready);
    modport sink   (input valid, input peak_position, input is_peak, input run_last,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/windowed_local_peak_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_local_peak_finder: streaming local maximum detector
// Finds samples that turn the slope downward and that no sample exceeds from
// half_window+2 samples before them up to, not including, half_window after;
// reports 1-based peak positions and a closing result at each series end.
//
//   channel       dir  handshake     payload
//   i_sample_if   in   valid/ready   sample, series_end
//   o_peak_if     out  valid/ready   peak_position, is_peak, run_last
//   i_cfg_*       in   write enable  half_window
//
// The back end pops a job, then checks each candidate's mark; a candidate that
// passes has its value read and its window scanned, the window being up to
// 2*half_window+2 history reads on its single read port. A series end resolves
// up to half_window+2 candidates and the closing result; new samples wait from
// its acceptance until the closing result is issued, and whenever the
// two-entry job queue is full.
// Synchronous active-low reset; no clearing pass. Both sides may stall freely.
// ----------------------------------------------------------------------------
module windowed_local_peak_finder #(
    parameter int HISTORY_DEPTH   = wlpf_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_HALF_WINDOW = wlpf_pkg::MAX_HALF_WINDOW_DEF,
    parameter int SAMPLE_WIDTH    = wlpf_pkg::SAMPLE_WIDTH_DEF,
    parameter int INDEX_WIDTH     = wlpf_pkg::INDEX_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [wlpf_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    wlpf_in_if.sink                        i_sample_if,
    wlpf_out_if.source                     o_peak_if
);
    import wlpf_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int HW_W   = $clog2(MAX_HALF_WINDOW + 1);

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] p_lo;
        logic [SLOT_W-1:0]      slot_lo;
        logic [INDEX_WIDTH-1:0] p_hi;
        logic [INDEX_WIDTH-1:0] cap;
        logic                   has_cand;
        logic                   series_last;
    } t_job;

    typedef struct packed {
        logic                           we;
        logic [SLOT_W-1:0]              slot;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           mark_we;
        logic [SLOT_W-1:0]              mark_slot;
        logic                           mark_val;
    } t_hist_wr;

    logic            fe_job_valid;
    t_job            fe_job;
    logic            q_ready;
    logic            q_valid;
    t_job            q_job;
    logic            be_pop;
    logic            be_close_done;
    t_hist_wr        hist_wr;
    logic [HW_W-1:0] half_window;

    // intake and classification
    wlpf_front #(
        .HISTORY_DEPTH   (HISTORY_DEPTH),
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .INDEX_WIDTH     (INDEX_WIDTH),
        .t_job           (t_job),
        .t_hist_wr       (t_hist_wr)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_sample_if   (i_sample_if),
        .o_job_valid   (fe_job_valid),
        .o_job         (fe_job),
        .i_job_ready   (q_ready),
        .o_wr          (hist_wr),
        .o_half_window (half_window),
        .i_close_done  (be_close_done)
    );

    // job queue
    wlpf_queue #(
        .t_job (t_job)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_job_valid),
        .i_data  (fe_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_job),
        .i_pop   (be_pop)
    );

    // resolution and result output
    wlpf_back #(
        .HISTORY_DEPTH   (HISTORY_DEPTH),
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .INDEX_WIDTH     (INDEX_WIDTH),
        .t_job           (t_job),
        .t_hist_wr       (t_hist_wr)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (hist_wr),
        .i_half_window (half_window),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_job_pop     (be_pop),
        .o_close_done  (be_close_done),
        .o_peak_if     (o_peak_if)
    );

endmodule
`default_nettype wire

FILE: rtl/wlpf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlpf_front: sample intake and job classification
// Holds the half window register, tracks the position in the series, marks
// candidates from the slope signs and issues resolution jobs to the queue.
// ----------------------------------------------------------------------------
module wlpf_front #(
    parameter int  HISTORY_DEPTH   = wlpf_pkg::HISTORY_DEPTH_DEF,
    parameter int  MAX_HALF_WINDOW = wlpf_pkg::MAX_HALF_WINDOW_DEF,
    parameter int  SAMPLE_WIDTH    = wlpf_pkg::SAMPLE_WIDTH_DEF,
    parameter int  INDEX_WIDTH     = wlpf_pkg::INDEX_WIDTH_DEF,
    parameter type t_job           = logic,
    parameter type t_hist_wr       = logic
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_cfg_we,
    input  wire  [wlpf_pkg::CFG_WIDTH-1:0]           i_cfg_wdata,
    wlpf_in_if.sink                                  i_sample_if,
    output logic                                     o_job_valid,
    output t_job                                     o_job,
    input  wire                                      i_job_ready,
    output t_hist_wr                                 o_wr,
    output logic [$clog2(MAX_HALF_WINDOW+1)-1:0]     o_half_window,
    input  wire                                      i_close_done
);
    import wlpf_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int HW_W   = $clog2(MAX_HALF_WINDOW + 1);
    localparam int CW     = $clog2(2 * HISTORY_DEPTH + MAX_HALF_WINDOW + 3);
    localparam int HW_RST = (int'(HALF_WINDOW_RST) > MAX_HALF_WINDOW) ?
                            MAX_HALF_WINDOW : int'(HALF_WINDOW_RST);
    localparam logic [SLOT_W-1:0]      SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [INDEX_WIDTH-1:0] IDX_LAST  = {INDEX_WIDTH{1'b1}};

    logic [HW_W-1:0]               r_hw;
    logic [INDEX_WIDTH-1:0]        r_idx;
    logic [SLOT_W-1:0]             r_slot;
    logic signed [SAMPLE_WIDTH-1:0] r_prev1;
    logic signed [SAMPLE_WIDTH-1:0] r_prev2;
    logic                          r_busy;

    logic                          accept;
    logic                          idx_ge2;
    logic                          idx_ge_m3;
    logic [INDEX_WIDTH-1:0]        p_new;
    logic [CW-1:0]                 slot_sub;
    logic [SLOT_W-1:0]             slot_p;
    logic [SLOT_W-1:0]             slot_prev;
    logic signed [1:0]             slope_after;
    logic signed [1:0]             slope_before;
    logic                          cand;
    logic signed [SAMPLE_WIDTH-1:0] x;

    // half window register, saturated to the supported maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw <= HW_W'(HW_RST);
        end else if (i_cfg_we) begin
            r_hw <= (32'(i_cfg_wdata) > 32'(MAX_HALF_WINDOW)) ?
                    HW_W'(MAX_HALF_WINDOW) : HW_W'(i_cfg_wdata);
        end
    end

    assign o_half_window = r_hw;

    // intake handshake, held off while a series end is being flushed or the job queue is full
    assign i_sample_if.ready = !r_busy && i_job_ready;
    assign accept            = i_sample_if.valid && i_sample_if.ready;
    assign x                 = i_sample_if.sample;

    // position classification
    assign idx_ge2   = r_idx >= INDEX_WIDTH'(2);
    assign idx_ge_m3 = {1'b0, r_idx} >= ((INDEX_WIDTH+1)'(r_hw) + (INDEX_WIDTH+1)'(3));
    assign p_new     = r_idx - INDEX_WIDTH'(r_hw) - INDEX_WIDTH'(2);

    // history slot of the candidate, modulo the depth
    assign slot_sub  = CW'(r_slot) + CW'(HISTORY_DEPTH) - CW'(r_hw) - CW'(2);
    assign slot_p    = (slot_sub >= CW'(HISTORY_DEPTH)) ?
                       SLOT_W'(slot_sub - CW'(HISTORY_DEPTH)) : SLOT_W'(slot_sub);
    assign slot_prev = (r_slot == '0) ? SLOT_LAST : r_slot - SLOT_W'(1);

    // slope signs around the previous sample
    always_comb begin
        if (x > r_prev1) begin
            slope_after = 2'sd1;
        end else if (x < r_prev1) begin
            slope_after = -2'sd1;
        end else begin
            slope_after = 2'sd0;
        end
        if (r_prev1 > r_prev2) begin
            slope_before = 2'sd1;
        end else if (r_prev1 < r_prev2) begin
            slope_before = -2'sd1;
        end else begin
            slope_before = 2'sd0;
        end
    end

    assign cand = slope_after < slope_before;

    // history and mark write request
    always_comb begin
        o_wr           = '0;
        o_wr.we        = accept;
        o_wr.slot      = r_slot;
        o_wr.sample    = x;
        o_wr.mark_we   = accept && idx_ge2;
        o_wr.mark_slot = slot_prev;
        o_wr.mark_val  = cand;
    end

    // job for the back end
    always_comb begin
        o_job             = '0;
        o_job.cap         = r_idx - INDEX_WIDTH'(2);
        o_job.series_last = i_sample_if.series_end;
        if (i_sample_if.series_end) begin
            o_job.p_lo     = idx_ge_m3 ? p_new : INDEX_WIDTH'(1);
            o_job.slot_lo  = idx_ge_m3 ? slot_p : SLOT_W'(1);
            o_job.p_hi     = r_idx - INDEX_WIDTH'(1);
            o_job.has_cand = idx_ge2;
        end else begin
            o_job.p_lo     = p_new;
            o_job.slot_lo  = slot_p;
            o_job.p_hi     = p_new;
            o_job.has_cand = 1'b1;
        end
    end

    assign o_job_valid = accept && (i_sample_if.series_end || idx_ge_m3);

    // series position and flush hold-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_slot <= '0;
            r_busy <= 1'b0;
        end else if (accept) begin
            if (i_sample_if.series_end) begin
                r_idx  <= '0;
                r_slot <= '0;
                r_busy <= 1'b1;
            end else begin
                r_idx  <= r_idx + INDEX_WIDTH'(1);
                r_slot <= (r_idx == IDX_LAST || r_slot == SLOT_LAST) ?
                          '0 : r_slot + SLOT_W'(1);
            end
        end else if (i_close_done) begin
            r_busy <= 1'b0;
        end
    end

    // last two samples for the slope test
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev2 <= r_prev1;
            r_prev1 <= x;
        end
    end

    // checks
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_sample_if.ready)
        else $error("front accepts a request during a series flush");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sample_if.series_end) |=> (r_idx == '0 && r_slot == '0 && r_busy))
        else $error("series end did not restart the position");

    a_window_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hw) <= 32'(MAX_HALF_WINDOW))
        else $error("half window above its maximum");

endmodule
`default_nettype wire

FILE: rtl/wlpf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlpf_queue: job queue
// Short first-in first-out buffer that decouples intake from resolution.
// ----------------------------------------------------------------------------
module wlpf_queue #(
    parameter type t_job = logic
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_job i_data,
    output logic o_ready,
    output logic o_valid,
    output t_job o_data,
    input  wire  i_pop
);
    import wlpf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/wlpf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wlpf_back: candidate resolution
// Owns the sample history memory and candidate marks. For each job it walks
// the candidates, scans the window one stored sample a cycle and emits found
// peaks, then the closing result at a series end.
// ----------------------------------------------------------------------------
module wlpf_back #(
    parameter int  HISTORY_DEPTH   = wlpf_pkg::HISTORY_DEPTH_DEF,
    parameter int  MAX_HALF_WINDOW = wlpf_pkg::MAX_HALF_WINDOW_DEF,
    parameter int  SAMPLE_WIDTH    = wlpf_pkg::SAMPLE_WIDTH_DEF,
    parameter int  INDEX_WIDTH     = wlpf_pkg::INDEX_WIDTH_DEF,
    parameter type t_job           = logic,
    parameter type t_hist_wr       = logic
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  t_hist_wr                             i_wr,
    input  wire  [$clog2(MAX_HALF_WINDOW+1)-1:0] i_half_window,
    input  wire                                  i_job_valid,
    input  t_job                                 i_job,
    output logic                                 o_job_pop,
    output logic                                 o_close_done,
    wlpf_out_if.source                           o_peak_if
);
    import wlpf_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int DW     = $clog2(MAX_HALF_WINDOW + 3);
    localparam int CNT_W  = $clog2(2 * MAX_HALF_WINDOW + 3);
    localparam int CW     = $clog2(2 * HISTORY_DEPTH + MAX_HALF_WINDOW + 3);
    localparam int PX_W   = (INDEX_WIDTH > POS_WIDTH) ? INDEX_WIDTH : POS_WIDTH;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
    endfunction

    // history memory and marks
    logic signed [SAMPLE_WIDTH-1:0] r_hist [HISTORY_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_rdata;
    logic [HISTORY_DEPTH-1:0]       r_marks;
    logic [HISTORY_DEPTH-1:0]       n_marks;
    logic [SLOT_W-1:0]              rd_slot;

    // sequencer
    t_back_state             r_state;
    t_back_state             n_state;
    logic [INDEX_WIDTH-1:0]  r_p, n_p;
    logic [SLOT_W-1:0]       r_pslot, n_pslot;
    logic [INDEX_WIDTH-1:0]  r_phi, n_phi;
    logic [INDEX_WIDTH-1:0]  r_cap, n_cap;
    logic                    r_last, n_last;
    logic [INDEX_WIDTH-1:0]  r_lb, n_lb;
    logic [INDEX_WIDTH-1:0]  r_rb, n_rb;
    logic [SLOT_W-1:0]       r_lbslot, n_lbslot;
    logic [SLOT_W-1:0]       r_jslot, n_jslot;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic signed [SAMPLE_WIDTH-1:0] r_v, n_v;

    // output register
    logic                    r_out_valid;
    logic [POS_WIDTH-1:0]    r_out_pos, n_out_pos;
    logic                    r_out_pk, n_out_pk;
    logic                    r_out_last, n_out_last;
    logic                    ld_out;
    logic                    out_free;

    // window bounds helpers
    logic                    p_ge_m2;
    logic [DW-1:0]           lb_dist;
    logic [INDEX_WIDTH:0]    p_plus_m;
    logic [CW-1:0]           lb_sub;
    logic [INDEX_WIDTH-1:0]  win_len;
    logic [PX_W-1:0]         pos_ext;

    assign out_free = !r_out_valid || o_peak_if.ready;

    assign p_ge_m2  = {1'b0, r_p} >= ((INDEX_WIDTH+1)'(i_half_window) + (INDEX_WIDTH+1)'(2));
    assign lb_dist  = p_ge_m2 ? (DW'(i_half_window) + DW'(2)) : DW'(r_p);
    assign p_plus_m = {1'b0, r_p} + (INDEX_WIDTH+1)'(i_half_window);
    assign lb_sub   = CW'(r_pslot) + CW'(HISTORY_DEPTH) - CW'(lb_dist);
    assign win_len  = (r_rb > r_lb) ? r_rb - r_lb : '0;
    assign pos_ext  = PX_W'(r_p + INDEX_WIDTH'(1));

    // memory write from intake, registered read for the sequencer
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_hist[i_wr.slot] <= i_wr.sample;
        end
        r_rdata <= r_hist[rd_slot];
    end

    // mark updates from intake
    always_comb begin
        n_marks = r_marks;
        if (i_wr.we) begin
            n_marks[i_wr.slot] = 1'b0;
        end
        if (i_wr.mark_we) begin
            n_marks[i_wr.mark_slot] = i_wr.mark_val;
        end
    end

    // candidate marks, cleared when a series closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_close_done) begin
            r_marks <= '0;
        end else begin
            r_marks <= n_marks;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer datapath registers
    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_pslot  <= n_pslot;
        r_phi    <= n_phi;
        r_cap    <= n_cap;
        r_last   <= n_last;
        r_lb     <= n_lb;
        r_rb     <= n_rb;
        r_lbslot <= n_lbslot;
        r_jslot  <= n_jslot;
        r_cnt    <= n_cnt;
        r_v      <= n_v;
    end

    // next state and sequencer outputs
    always_comb begin
        n_state      = r_state;
        n_p          = r_p;
        n_pslot      = r_pslot;
        n_phi        = r_phi;
        n_cap        = r_cap;
        n_last       = r_last;
        n_lb         = r_lb;
        n_rb         = r_rb;
        n_lbslot     = r_lbslot;
        n_jslot      = r_jslot;
        n_cnt        = r_cnt;
        n_v          = r_v;
        n_out_pos    = r_out_pos;
        n_out_pk     = r_out_pk;
        n_out_last   = r_out_last;
        ld_out       = 1'b0;
        o_job_pop    = 1'b0;
        o_close_done = 1'b0;
        rd_slot      = r_pslot;

        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_p       = i_job.p_lo;
                    n_pslot   = i_job.slot_lo;
                    n_phi     = i_job.p_hi;
                    n_cap     = i_job.cap;
                    n_last    = i_job.series_last;
                    n_state   = i_job.has_cand ? B_CHECK : B_CLOSE;
                end
            end
            B_CHECK: begin
                // read the candidate value and fix the window bounds
                rd_slot = r_pslot;
                if (r_marks[r_pslot]) begin
                    n_lb     = r_p - INDEX_WIDTH'(lb_dist);
                    n_rb     = (p_plus_m < {1'b0, r_cap}) ?
                               p_plus_m[INDEX_WIDTH-1:0] : r_cap;
                    n_lbslot = (lb_sub >= CW'(HISTORY_DEPTH)) ?
                               SLOT_W'(lb_sub - CW'(HISTORY_DEPTH)) : SLOT_W'(lb_sub);
                    n_state  = B_VAL;
                end else begin
                    n_state = B_NEXT;
                end
            end
            B_VAL: begin
                // candidate value arrives, first window read goes out
                n_v     = r_rdata;
                rd_slot = r_lbslot;
                n_jslot = slot_inc(r_lbslot);
                if (win_len == '0) begin
                    n_state = B_EMIT;
                end else begin
                    n_cnt   = CNT_W'(win_len);
                    n_state = B_SCAN;
                end
            end
            B_SCAN: begin
                // one window sample a cycle
                rd_slot = r_jslot;
                n_jslot = slot_inc(r_jslot);
                if (r_rdata > r_v) begin
                    n_state = B_NEXT;
                end else if (r_cnt == CNT_W'(1)) begin
                    n_state = B_EMIT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    ld_out     = 1'b1;
                    n_out_pos  = pos_ext[POS_WIDTH-1:0];
                    n_out_pk   = 1'b1;
                    n_out_last = 1'b0;
                    n_state    = B_NEXT;
                end
            end
            B_NEXT: begin
                if (r_p == r_phi) begin
                    n_state = r_last ? B_CLOSE : B_IDLE;
                end else begin
                    n_p     = r_p + INDEX_WIDTH'(1);
                    n_pslot = slot_inc(r_pslot);
                    n_state = B_CHECK;
                end
            end
            B_CLOSE: begin
                if (out_free) begin
                    ld_out       = 1'b1;
                    n_out_pos    = '0;
                    n_out_pk     = 1'b0;
                    n_out_last   = 1'b1;
                    o_close_done = 1'b1;
                    n_state      = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // output register, taken by the sink independently of the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_peak_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_pos  <= n_out_pos;
            r_out_pk   <= n_out_pk;
            r_out_last <= n_out_last;
        end
    end

    assign o_peak_if.valid         = r_out_valid;
    assign o_peak_if.peak_position = r_out_pos;
    assign o_peak_if.is_peak       = r_out_pk;
    assign o_peak_if.run_last      = r_out_last;

    // checks
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SCAN) |-> (r_cnt != '0))
        else $error("window scan with no samples left");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_out |-> (!r_out_valid || o_peak_if.ready))
        else $error("pending result overwritten");

    a_marks_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_close_done |=> (r_marks == '0))
        else $error("candidate marks survive the series end");

    a_close_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (!r_out_pk && r_out_pos == '0))
        else $error("closing result carries a peak");

endmodule
`default_nettype wire

FILE: tb/peak_finder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_finder_checker: result scoreboard of the windowed local peak finder
// Watches the sample channel and the configuration port, works out the peak
// positions and closing results that each accepted request must produce, and
// compares every accepted result with the oldest one still expected.
// ----------------------------------------------------------------------------
module peak_finder_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [wlpf_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    wlpf_in_if                             i_sample_if,
    wlpf_out_if                            i_peak_if,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_peaks,
    output int                             o_closings
);
    import wlpf_pkg::*;

    localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
    localparam int SW         = SAMPLE_WIDTH_DEF;
    localparam int IW         = INDEX_WIDTH_DEF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [POS_WIDTH-1:0] position;
        logic                 is_peak;
        logic                 run_last;
    } t_peak_result;

    // local copy of the block state
    logic signed [SW-1:0] history [HIST_DEPTH];
    bit                   turn_marks [HIST_DEPTH];
    bit [IW-1:0]          next_pos;
    int unsigned          window;
    t_peak_result         expected_peaks [$];

    initial begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
            history[k]    = '0;
            turn_marks[k] = 1'b0;
        end
        next_pos     = '0;
        window       = int'(HALF_WINDOW_RST);
        o_mismatches = 0;
        o_pending    = 0;
        o_peaks      = 0;
        o_closings   = 0;
    end

    function automatic int slot(input int k);
        return k % HIST_DEPTH;
    endfunction

    function automatic int slope(input logic signed [SW-1:0] a, input logic signed [SW-1:0] b);
        return (a > b) ? 1 : ((a < b) ? -1 : 0);
    endfunction

    // marked turning point that no sample in [p-m-2, rb) exceeds
    function automatic bit dominates(input int p, input int rb, input int m);
        int lb;
        if (!turn_marks[slot(p)])
            return 1'b0;
        lb = p - m - 2;
        if (lb < 0)
            lb = 0;
        for (int j = lb; j < rb; j++) begin
            if (history[slot(j)] > history[slot(p)])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic expect_result(input int pos, input bit pk, input bit last);
        t_peak_result r;
        r.position = POS_WIDTH'(pos);
        r.is_peak  = pk;
        r.run_last = last;
        expected_peaks.push_back(r);
    endtask

    // work out the results of one accepted sample request
    task automatic predict_peaks(input logic signed [SW-1:0] x, input bit last);
        int n;
        int m;
        int p;
        int rb;
        n = int'(next_pos);
        m = int'(window);
        history[slot(n)]    = x;
        turn_marks[slot(n)] = 1'b0;
        if (n >= 2)
            turn_marks[slot(n - 1)] = (slope(x, history[slot(n - 1)])
                                       - slope(history[slot(n - 1)], history[slot(n - 2)])) < 0;
        if (!last) begin
            if (n >= m + 3) begin
                p = n - m - 2;
                if (dominates(p, p + m, m))
                    expect_result(p + 1, 1'b1, 1'b0);
            end
            next_pos = next_pos + IW'(1);
        end else begin
            // flush every pending candidate, then the closing result
            if (n >= 2) begin
                p = (n >= m + 3) ? (n - m - 2) : 1;
                for (; p <= n - 1; p++) begin
                    rb = (p + m > n - 2) ? (n - 2) : (p + m);
                    if (dominates(p, rb, m))
                        expect_result(p + 1, 1'b1, 1'b0);
                end
            end
            expect_result(0, 1'b0, 1'b1);
            next_pos = '0;
            for (int k = 0; k < HIST_DEPTH; k++)
                turn_marks[k] = 1'b0;
        end
    endtask

    task automatic check_result();
        t_peak_result got;
        t_peak_result want;
        got.position = i_peak_if.peak_position;
        got.is_peak  = i_peak_if.is_peak;
        got.run_last = i_peak_if.run_last;
        if (got.is_peak === 1'b1)
            o_peaks++;
        if (got.run_last === 1'b1)
            o_closings++;
        if (expected_peaks.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= REPORT_MAX)
                $display("%0t: unexpected result pos=%0d is_peak=%b run_last=%b",
                         $realtime, got.position, got.is_peak, got.run_last);
        end else begin
            want = expected_peaks.pop_front();
            if (got.position !== want.position || got.is_peak !== want.is_peak
                    || got.run_last !== want.run_last) begin
                o_mismatches++;
                if (o_mismatches <= REPORT_MAX)
                    $display("%0t: exp pos=%0d pk=%b last=%b, got pos=%0d pk=%b last=%b",
                             $realtime, want.position, want.is_peak, want.run_last,
                             got.position, got.is_peak, got.run_last);
            end
        end
    endtask

    // results first, then register writes and new sample requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_peak_if.valid && i_peak_if.ready)
                check_result();
            if (i_cfg_we)
                window = int'(i_cfg_wdata);
            if (i_sample_if.valid && i_sample_if.ready)
                predict_peaks(i_sample_if.sample, i_sample_if.series_end);
            o_pending = expected_peaks.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the windowed local peak finder
// Drives sample series under several half_window settings and flow-control
// patterns: directed short and extreme series, random-walk series and a long
// receiver hold-off. The checker beside the block predicts and compares the
// results.
// ----------------------------------------------------------------------------
module tb_top;
    import wlpf_pkg::*;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int SETTLE_WAIT  = 800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 35;
    localparam int HOLD_CYCLES  = 600;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_WIDTH-1:0] cfg_wdata;
    logic                 hold_off;

    int mismatches;
    int pending_results;
    int peaks_checked;
    int closings_checked;
    int sender_idle_pct;
    int sink_stall_pct;
    int samples_sent;
    int series_sent;
    int series_left;
    int cycle_count;
    logic signed [SW-1:0] walk_value;

    wlpf_in_if  sample_ch ();
    wlpf_out_if peak_ch ();

    windowed_local_peak_finder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_sample_if (sample_ch),
        .o_peak_if   (peak_ch)
    );

    peak_finder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_sample_if  (sample_ch),
        .i_peak_if    (peak_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending_results),
        .o_peaks      (peaks_checked),
        .o_closings   (closings_checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results);
            $display("Mismatches found");
            $finish;
        end
    end

    // result receiver with random stalls and an optional hold-off
    always @(posedge i_clk) begin
        peak_ch.ready <= !hold_off && (int'($urandom_range(99)) >= sink_stall_pct);
    end

    // random walk with plateaus, rail values and jumps
    function automatic logic signed [SW-1:0] next_sample(input logic signed [SW-1:0] prev);
        int                   r;
        int                   v;
        logic signed [SW-1:0] jump;
        r = int'($urandom_range(99));
        if (r < 55) begin
            v = int'(prev) + int'($urandom_range(400)) - 200;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
        end else if (r < 70) begin
            v = int'(prev);
        end else if (r < 80) begin
            v = ($urandom_range(1) != 0) ? 32767 : -32768;
        end else begin
            jump = SW'($urandom());
            v    = int'(jump);
        end
        return SW'(v);
    endfunction

    // offer one sample request and wait for it to be taken
    task automatic send_sample(input logic signed [SW-1:0] value, input bit last);
        if (sender_idle_pct != 0 && int'($urandom_range(99)) < sender_idle_pct) begin
            sample_ch.valid <= 1'b0;
            do
                @(posedge i_clk);
            while (int'($urandom_range(99)) < sender_idle_pct);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.sample     <= value;
        sample_ch.series_end <= last;
        @(posedge i_clk);
        while (!sample_ch.ready)
            @(posedge i_clk);
        samples_sent++;
        if (last)
            series_sent++;
    endtask

    // let the block drain, then write the window register
    task automatic apply_half_window(input logic [CFG_WIDTH-1:0] value);
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // random series; an unfinished series carries over into the next setting
    task automatic random_phase(input int items);
        int r;
        repeat (items) begin
            if (series_left == 0) begin
                r = int'($urandom_range(99));
                if (r < 10)
                    series_left = int'($urandom_range(2, 1));
                else if (r < 85)
                    series_left = int'($urandom_range(40, 3));
                else
                    series_left = int'($urandom_range(90, 41));
            end
            series_left--;
            walk_value = next_sample(walk_value);
            send_sample(walk_value, series_left == 0);
        end
    endtask

    // fixed series: single sample, two samples, shortest with a peak, extremes
    localparam int DIRECTED_LEN = 20;
    localparam logic signed [SW-1:0] DIRECTED_SAMPLES [DIRECTED_LEN] = '{
        16'sh7FFF,
        16'sh8000, 16'sh7FFF,
        16'sh0000, 16'sh7FFF, 16'sh8000,
        16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh0001, 16'sh0001, 16'sh0000,
        16'shFFFF, 16'sh0002, 16'sh8000, 16'sh7FFF, 16'sh5555, 16'shAAAA, 16'sh8000
    };
    localparam bit DIRECTED_LAST [DIRECTED_LEN] = '{
        1'b1,
        1'b0, 1'b1,
        1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
    };

    // stimulus and verdict
    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        hold_off             = 1'b0;
        sample_ch.valid      = 1'b0;
        sample_ch.sample     = '0;
        sample_ch.series_end = 1'b0;
        peak_ch.ready        = 1'b0;
        sender_idle_pct      = 0;
        sink_stall_pct       = 0;
        samples_sent         = 0;
        series_sent          = 0;
        series_left          = 0;
        cycle_count          = 0;
        walk_value           = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed series at the reset window
        for (int k = 0; k < DIRECTED_LEN; k++)
            send_sample(DIRECTED_SAMPLES[k], DIRECTED_LAST[k]);

        // narrowest window, no idling
        apply_half_window(CFG_WIDTH'(0));
        random_phase(PHASE_ITEMS);

        // widest window, sender idles
        apply_half_window(CFG_WIDTH'(15));
        sender_idle_pct = 47;
        random_phase(PHASE_ITEMS);

        // receiver stalls and holds off while samples keep coming
        apply_half_window(CFG_WIDTH'(7));
        sender_idle_pct = 0;
        sink_stall_pct  = 47;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        random_phase(PHASE_ITEMS);

        // both sides idle
        apply_half_window(CFG_WIDTH'(1));
        sender_idle_pct = 20;
        sink_stall_pct  = 20;
        random_phase(PHASE_ITEMS);
        if (series_left != 0) begin
            walk_value = next_sample(walk_value);
            send_sample(walk_value, 1'b1);
            series_left = 0;
        end

        // drain
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("sent %0d samples in %0d series over half_window 3, 0, 15, 7 and 1,",
                 samples_sent, series_sent);
        $display("with a long receiver hold-off; checked %0d peaks and %0d closing results",
                 peaks_checked, closings_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
